>>> rtl/coe_pkg.sv
// Shared constants, types and helpers of the circular orbit evaluator.
`timescale 1ns / 1ps
`default_nettype none
package coe_pkg;

  // Two pi in Q.60, the modulus of the angle reduction.
  localparam logic [63:0] TWO_PI60 = 64'h6487ED5110B4611A;
  localparam int unsigned REM_W = 63;

  // Angle word for the fold and the CORDIC, signed Q.32.
  localparam int unsigned Z_W = 37;
  localparam logic signed [Z_W-1:0] PI32      = 37'sd13493037705;
  localparam logic signed [Z_W-1:0] TWO_PI32  = 37'sd26986075409;
  localparam logic signed [Z_W-1:0] HALF_PI32 = 37'sd6746518852;

  // CORDIC vectors are signed Q.30.
  localparam int unsigned XY_W = 32;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // Magnitude of w*r in Q19.16.
  localparam int unsigned WR_W = 35;

  localparam logic [31:0] TICK_PERIOD_RESET = 32'd71582788;

  // atan(2^-i) in Q.32.
  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635, 32'd268086748,
    32'd134174063, 32'd67103403, 32'd33553749, 32'd16777131, 32'd8388597,
    32'd4194303, 32'd2097152, 32'd1048576, 32'd524288, 32'd262144, 32'd131072,
    32'd65536, 32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024,
    32'd512, 32'd256, 32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  // Per-item data that rides along the CORDIC pipeline.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        r;
    logic [WR_W-1:0]    wr_mag;
    logic               wr_neg;
    logic               flip;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > 40'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/coe_orbit_if.sv
// Input channel carrying one orbit item.
`timescale 1ns / 1ps
`default_nettype none
interface coe_orbit_if;
  logic               valid;
  logic               ready;
  logic [63:0]        base_tick;
  logic [63:0]        eval_tick;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0]        orbit_radius;
  logic signed [31:0] start_angle;
  logic signed [31:0] angular_rate;

  modport source (output valid, base_tick, eval_tick, center_x, center_y, orbit_radius,
                  start_angle, angular_rate, input ready);
  modport sink (input valid, base_tick, eval_tick, center_x, center_y, orbit_radius,
                start_angle, angular_rate, output ready);
endinterface
`default_nettype wire

>>> rtl/coe_result_if.sv
// Output channel carrying one position and velocity item.
`timescale 1ns / 1ps
`default_nettype none
interface coe_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface
`default_nettype wire

>>> rtl/coe_cfg_if.sv
// Configuration write channel for the tick period register.
`timescale 1ns / 1ps
`default_nettype none
interface coe_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_period;

  modport source (output valid, tick_period, input ready);
  modport sink (input valid, tick_period, output ready);
endinterface
`default_nettype wire

>>> rtl/circular_orbit_evaluator_top.sv
// Top level of the circular orbit evaluator: fully pipelined orbit to position and velocity.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one orbit item per clock (centre, radius, start angle, angular rate and two
// tick numbers) and returns one result item with position and velocity in Q16.16, saturated
// to 32 bits. The datapath is a single pipeline with no feedback, so the sustained rate is
// one item per cycle. Most of the pipeline depth comes from the reduction of the angle
// increment modulo two pi, which retires two bits per stage over 32 stages, and from the
// CORDIC, which spends one stage per iteration. All stages advance together; they hold only
// while the output register carries a result that the sink has not taken. The tick period
// register resets to one sixtieth of a second and is written through the configuration
// channel, which is always ready; it should be written only while no item is in flight.
module circular_orbit_evaluator_top #(
  parameter int TRIG_ITERATIONS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  coe_orbit_if.sink    orbit_i,
  coe_result_if.source result_o,
  coe_cfg_if.sink      cfg_i
);
  import coe_pkg::*;

  localparam int ITER_N     = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
  localparam int MOD_STAGES = 32;
  localparam int MOD_STEP   = 64 / MOD_STAGES;

  // Global pipeline enable: everything moves unless a result is stuck at the output.
  logic en;
  logic out_v_q;
  assign en            = !out_v_q || result_o.ready;
  assign orbit_i.ready = en;

  // Tick period register.
  logic [31:0] tp_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q <= TICK_PERIOD_RESET;
    end else if (cfg_i.valid) begin
      tp_q <= cfg_i.tick_period;
    end
  end

  // Stage 1: signed tick difference, saturated to the 32-bit range, as sign and magnitude.
  logic [64:0] diff;
  logic [63:0] diff_neg;
  logic [31:0] md_d;
  assign diff     = {1'b0, orbit_i.eval_tick} - {1'b0, orbit_i.base_tick};
  assign diff_neg = ~diff[63:0] + 64'd1;
  always_comb begin
    if (!diff[64]) begin
      md_d = (diff[63:0] > 64'h7FFFFFFF) ? 32'h7FFFFFFF : diff[31:0];
    end else begin
      md_d = (diff_neg > 64'h80000000) ? 32'h80000000 : diff_neg[31:0];
    end
  end

  logic               v1_q, dneg1_q;
  logic [31:0]        md1_q;
  logic signed [31:0] cx1_q, cy1_q, sa1_q, w1_q;
  logic [30:0]        r1_q;

  // Stage 2: elapsed time in Q32.32, |w|, w*r before rounding, start angle magnitude reduced.
  logic               v2_q, neg2_q, sa_neg2_q, w_neg2_q;
  logic [63:0]        me2_q;
  logic [31:0]        mr2_q;
  logic [REM_W-1:0]   ms2_q;
  logic [62:0]        wraw2_q;
  logic signed [31:0] cx2_q, cy2_q;
  logic [30:0]        r2_q;
  logic [31:0]        mr1;
  logic [31:0]        msa1;
  logic [63:0]        ms_raw1, ms_red1;
  assign mr1     = w1_q[31] ? (~w1_q + 32'd1) : w1_q;
  assign msa1    = sa1_q[31] ? (~sa1_q + 32'd1) : sa1_q;
  assign ms_raw1 = {msa1, 32'd0};
  assign ms_red1 = (ms_raw1 >= TWO_PI60) ? (ms_raw1 - TWO_PI60) : ms_raw1;

  // Stage 3: the two partial products of the angle increment, start angle sign, w*r rounded.
  logic               v3_q, neg3_q;
  logic [63:0]        pa3_q, pb3_q;
  logic [REM_W-1:0]   ms3_q;
  side_t              side3_q;
  logic [63:0]        wr_sum2;
  logic [63:0]        ms_neg2;
  assign wr_sum2 = {1'b0, wraw2_q} + 64'd134217728;
  assign ms_neg2 = TWO_PI60 - {1'b0, ms2_q};

  // Stage 4: full angle increment in Q.60.
  logic               v4_q, neg4_q;
  logic [95:0]        prod4_q;
  logic [REM_W-1:0]   ms4_q;
  side_t              side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= orbit_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      md1_q   <= md_d;
      dneg1_q <= diff[64];
      cx1_q   <= orbit_i.center_x;
      cy1_q   <= orbit_i.center_y;
      r1_q    <= orbit_i.orbit_radius;
      sa1_q   <= orbit_i.start_angle;
      w1_q    <= orbit_i.angular_rate;

      me2_q     <= {32'd0, md1_q} * {32'd0, tp_q};
      mr2_q     <= mr1;
      neg2_q    <= dneg1_q ^ w1_q[31];
      ms2_q     <= ms_red1[REM_W-1:0];
      sa_neg2_q <= sa1_q[31];
      wraw2_q   <= 63'(mr1 * r1_q);
      w_neg2_q  <= w1_q[31];
      cx2_q     <= cx1_q;
      cy2_q     <= cy1_q;
      r2_q      <= r1_q;

      pa3_q          <= {32'd0, me2_q[31:0]} * {32'd0, mr2_q};
      pb3_q          <= {32'd0, me2_q[63:32]} * {32'd0, mr2_q};
      neg3_q         <= neg2_q;
      ms3_q          <= (sa_neg2_q && ms2_q != '0) ? ms_neg2[REM_W-1:0] : ms2_q;
      side3_q.cx     <= cx2_q;
      side3_q.cy     <= cy2_q;
      side3_q.r      <= r2_q;
      side3_q.wr_mag <= wr_sum2[62:28];
      side3_q.wr_neg <= w_neg2_q;
      side3_q.flip   <= 1'b0;

      prod4_q <= {32'd0, pa3_q} + {pb3_q, 32'd0};
      neg4_q  <= neg3_q;
      ms4_q   <= ms3_q;
      side4_q <= side3_q;
    end
  end

  // Modulo two pi of the increment, long division by a constant, MOD_STEP bits a stage.
  logic             mv_q    [MOD_STAGES+1];
  logic [REM_W-1:0] rem_q   [MOD_STAGES+1];
  logic [63:0]      bits_q  [MOD_STAGES+1];
  logic             mneg_q  [MOD_STAGES+1];
  logic [REM_W-1:0] mms_q   [MOD_STAGES+1];
  side_t            mside_q [MOD_STAGES+1];

  assign mv_q[0]    = v4_q;
  assign rem_q[0]   = {{(REM_W-32){1'b0}}, prod4_q[95:64]};
  assign bits_q[0]  = prod4_q[63:0];
  assign mneg_q[0]  = neg4_q;
  assign mms_q[0]   = ms4_q;
  assign mside_q[0] = side4_q;

  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
    logic [REM_W-1:0] rem_d;
    logic [63:0]      bits_d;
    always_comb begin
      logic [63:0] trial;
      rem_d  = rem_q[k];
      bits_d = bits_q[k];
      for (int j = 0; j < MOD_STEP; j++) begin
        trial  = {rem_d, bits_d[63]};
        bits_d = {bits_d[62:0], 1'b0};
        if (trial >= TWO_PI60) begin
          trial = trial - TWO_PI60;
        end
        rem_d = trial[REM_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[k+1] <= 1'b0;
      end else if (en) begin
        mv_q[k+1] <= mv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1]   <= rem_d;
        bits_q[k+1]  <= bits_d;
        mneg_q[k+1]  <= mneg_q[k];
        mms_q[k+1]   <= mms_q[k];
        mside_q[k+1] <= mside_q[k];
      end
    end
  end

  // Sign of the increment, angle sum, final reduction, then the fold into [-pi/2, pi/2].
  logic               sv_q, av_q, tv_q, fv_q;
  logic [REM_W-1:0]   srem_q, sms_q;
  side_t              sside_q, aside_q, tside_q, fside_q;
  logic [63:0]        theta_q;
  logic [34:0]        t_q;
  logic signed [Z_W-1:0] z_q;
  logic [63:0]        rem_neg;
  logic [63:0]        theta_red;
  assign rem_neg   = TWO_PI60 - {1'b0, rem_q[MOD_STAGES]};
  assign theta_red = (theta_q >= TWO_PI60) ? (theta_q - TWO_PI60) : theta_q;

  logic signed [Z_W-1:0] tw;
  logic signed [Z_W-1:0] z_d;
  logic                  flip_d;
  side_t                 fside_d;
  always_comb begin
    tw = $signed({{(Z_W-35){1'b0}}, t_q});
    if (tw > PI32) begin
      tw = tw - TWO_PI32;
    end
    flip_d = 1'b0;
    z_d    = tw;
    if (tw > HALF_PI32) begin
      z_d    = tw - PI32;
      flip_d = 1'b1;
    end else if (tw < -HALF_PI32) begin
      z_d    = tw + PI32;
      flip_d = 1'b1;
    end
    fside_d      = tside_q;
    fside_d.flip = flip_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      av_q <= 1'b0;
      tv_q <= 1'b0;
      fv_q <= 1'b0;
    end else if (en) begin
      sv_q <= mv_q[MOD_STAGES];
      av_q <= sv_q;
      tv_q <= av_q;
      fv_q <= tv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      srem_q  <= (mneg_q[MOD_STAGES] && rem_q[MOD_STAGES] != '0) ?
                 rem_neg[REM_W-1:0] : rem_q[MOD_STAGES];
      sms_q   <= mms_q[MOD_STAGES];
      sside_q <= mside_q[MOD_STAGES];

      theta_q <= {1'b0, srem_q} + {1'b0, sms_q};
      aside_q <= sside_q;

      t_q     <= theta_red[62:28];
      tside_q <= aside_q;

      z_q     <= z_d;
      fside_q <= fside_d;
    end
  end

  // CORDIC for cosine and sine.
  logic                   cv;
  logic signed [XY_W-1:0] cx_o, cy_o;
  side_t                  cside;

  coe_cordic #(
    .ITER (ITER_N)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q),
    .z_i     (z_q),
    .side_i  (fside_q),
    .valid_o (cv),
    .x_o     (cx_o),
    .y_o     (cy_o),
    .side_o  (cside)
  );

  // Multiply stage: magnitudes times radius and times w*r, the latter split in two partials.
  logic [XY_W-1:0] ax, ay;
  assign ax = cx_o[XY_W-1] ? (~cx_o + 32'd1) : cx_o;
  assign ay = cy_o[XY_W-1] ? (~cy_o + 32'd1) : cy_o;

  logic               p1v_q;
  logic               nx1_q, ny1_q, nvx1_q, nvy1_q;
  logic [62:0]        px1_q, py1_q;
  logic [63:0]        vxl1_q, vyl1_q;
  logic [34:0]        vxh1_q, vyh1_q;
  logic signed [31:0] pcx1_q, pcy1_q;

  // Rounding stage.
  logic               p2v_q;
  logic               nx2_q, ny2_q, nvx2_q, nvy2_q;
  logic [33:0]        mpx2_q, mpy2_q;
  logic [37:0]        mvx2_q, mvy2_q;
  logic signed [31:0] pcx2_q, pcy2_q;
  logic [63:0]        rpx, rpy;
  logic [67:0]        rvx, rvy;
  assign rpx = {1'b0, px1_q} + 64'd536870912;
  assign rpy = {1'b0, py1_q} + 64'd536870912;
  assign rvx = {1'b0, vxh1_q, 32'd0} + {4'd0, vxl1_q} + 68'd536870912;
  assign rvy = {1'b0, vyh1_q, 32'd0} + {4'd0, vyl1_q} + 68'd536870912;

  // Output stage: signs, centre offset and saturation.
  logic signed [39:0] spx, spy, svx, svy;
  assign spx = $signed({{8{pcx2_q[31]}}, pcx2_q}) +
               (nx2_q ? -$signed({6'd0, mpx2_q}) : $signed({6'd0, mpx2_q}));
  assign spy = $signed({{8{pcy2_q[31]}}, pcy2_q}) +
               (ny2_q ? -$signed({6'd0, mpy2_q}) : $signed({6'd0, mpy2_q}));
  // Velocity x is minus w*r*sin, so a negative product gives a positive result.
  assign svx = nvx2_q ? $signed({2'd0, mvx2_q}) : -$signed({2'd0, mvx2_q});
  assign svy = nvy2_q ? -$signed({2'd0, mvy2_q}) : $signed({2'd0, mvy2_q});

  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1v_q   <= 1'b0;
      p2v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p1v_q   <= cv;
      p2v_q   <= p1v_q;
      out_v_q <= p2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q  <= {32'd0, cside.r} * {31'd0, ax};
      py1_q  <= {32'd0, cside.r} * {31'd0, ay};
      vxl1_q <= {32'd0, cside.wr_mag[31:0]} * {32'd0, ay};
      vxh1_q <= {32'd0, cside.wr_mag[34:32]} * ay;
      vyl1_q <= {32'd0, cside.wr_mag[31:0]} * {32'd0, ax};
      vyh1_q <= {32'd0, cside.wr_mag[34:32]} * ax;
      nx1_q  <= cx_o[XY_W-1] ^ cside.flip;
      ny1_q  <= cy_o[XY_W-1] ^ cside.flip;
      nvx1_q <= cside.wr_neg ^ cy_o[XY_W-1] ^ cside.flip;
      nvy1_q <= cside.wr_neg ^ cx_o[XY_W-1] ^ cside.flip;
      pcx1_q <= cside.cx;
      pcy1_q <= cside.cy;

      mpx2_q <= rpx[63:30];
      mpy2_q <= rpy[63:30];
      mvx2_q <= rvx[67:30];
      mvy2_q <= rvy[67:30];
      nx2_q  <= nx1_q;
      ny2_q  <= ny1_q;
      nvx2_q <= nvx1_q;
      nvy2_q <= nvy1_q;
      pcx2_q <= pcx1_q;
      pcy2_q <= pcy1_q;

      pos_x_q <= sat32(spx);
      pos_y_q <= sat32(spy);
      vel_x_q <= sat32(svx);
      vel_y_q <= sat32(svy);
    end
  end

  assign result_o.valid = out_v_q;
  assign result_o.pos_x = pos_x_q;
  assign result_o.pos_y = pos_y_q;
  assign result_o.vel_x = vel_x_q;
  assign result_o.vel_y = vel_y_q;

endmodule
`default_nettype wire

>>> rtl/coe_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per register stage.
`timescale 1ns / 1ps
`default_nettype none
module coe_cordic #(
  parameter int ITER = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [coe_pkg::Z_W-1:0]    z_i,
  input  coe_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [coe_pkg::XY_W-1:0]   x_o,
  output logic signed [coe_pkg::XY_W-1:0]   y_o,
  output coe_pkg::side_t                    side_o
);
  import coe_pkg::*;

  logic                   v_q    [ITER+1];
  logic signed [XY_W-1:0] x_q    [ITER+1];
  logic signed [XY_W-1:0] y_q    [ITER+1];
  logic signed [Z_W-1:0]  z_q    [ITER+1];
  side_t                  side_q [ITER+1];

  assign v_q[0]    = valid_i;
  assign x_q[0]    = CORDIC_GAIN;
  assign y_q[0]    = '0;
  assign z_q[0]    = z_i;
  assign side_q[0] = side_i;

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [Z_W-1:0] atan_s;
    assign atan_s = $signed({{(Z_W-32){1'b0}}, ATAN_Q32[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        if (!z_q[i][Z_W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_s;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_s;
        end
      end
    end
  end

  assign valid_o = v_q[ITER];
  assign x_o     = x_q[ITER];
  assign y_o     = y_q[ITER];
  assign side_o  = side_q[ITER];

endmodule
`default_nettype wire
